>>> hw/rtl/tts_pkg.sv
package tts_pkg;

   localparam int DATA_W        = 32;
   localparam int IDX_W         = 6;
   localparam int DEF_MAX_ROWS  = 64;
   localparam int DEF_FRAC_BITS = 24;

   typedef struct packed {
      logic load_in;
      logic calc_prod;
      logic calc_piv;
      logic div_start;
      logic fwd_write;
      logic back_mul;
      logic back_sub;
      logic idx_dec;
      logic run_clear;
   } tts_cmd_type;

   typedef struct packed {
      logic piv_zero;
      logic div_done;
      logic final_row;
      logic idx_zero;
   } tts_stat_type;

endpackage

>>> hw/rtl/tts_ram.sv
module tts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hw/rtl/tts_div.sv
module tts_div #(
   parameter int NW = 56
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [31:0]   divisor,
   output logic [NW-1:0] quotient,
   output logic          done
);
   localparam int CW = $clog2(NW + 1);

   logic [31:0]   rem_ff, rem_in;
   logic [NW-1:0] sh_ff, sh_in;
   logic [31:0]   dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [32:0]   trial;
   logic          ge;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, sh_ff[NW-1]};
      ge      = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         sh_in   = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(NW);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         rem_in = ge ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
         sh_in  = {sh_ff[NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = sh_ff;
   assign done     = done_ff;
endmodule

>>> hw/rtl/tts_ctrl.sv
module tts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  tts_pkg::tts_stat_type stat,
   output tts_pkg::tts_cmd_type  cmd
);
   import tts_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL  = 4'd1;
   localparam logic [3:0] S_PIV  = 4'd2;
   localparam logic [3:0] S_DIV  = 4'd3;
   localparam logic [3:0] S_DIVW = 4'd4;
   localparam logic [3:0] S_WR   = 4'd5;
   localparam logic [3:0] S_BRD  = 4'd6;
   localparam logic [3:0] S_BMUL = 4'd7;
   localparam logic [3:0] S_BSUB = 4'd8;
   localparam logic [3:0] S_BOUT = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.calc_prod = 1'b1;
            state_in      = S_PIV;
         end
         S_PIV: begin
            cmd.calc_piv = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            if (stat.piv_zero) begin
               state_in = S_WR;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVW;
            end
         end
         S_DIVW: begin
            if (stat.div_done) begin
               state_in = S_WR;
            end
         end
         S_WR: begin
            cmd.fwd_write = 1'b1;
            state_in      = stat.final_row ? S_BRD : S_IDLE;
         end
         S_BRD: begin
            state_in = S_BMUL;
         end
         S_BMUL: begin
            cmd.back_mul = 1'b1;
            state_in     = S_BSUB;
         end
         S_BSUB: begin
            cmd.back_sub = 1'b1;
            state_in     = S_BOUT;
         end
         S_BOUT: begin
            if (rsp_ready) begin
               if (stat.idx_zero) begin
                  cmd.run_clear = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.idx_dec = 1'b1;
                  state_in    = S_BRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_BOUT;
endmodule

>>> hw/rtl/tts_dp.sv
module tts_dp #(
   parameter int MAX_ROWS  = tts_pkg::DEF_MAX_ROWS,
   parameter int FRAC_BITS = tts_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tts_pkg::tts_cmd_type          cmd,
   output tts_pkg::tts_stat_type         stat,
   input  logic signed [tts_pkg::DATA_W-1:0] req_sub_diag,
   input  logic signed [tts_pkg::DATA_W-1:0] req_main_diag,
   input  logic signed [tts_pkg::DATA_W-1:0] req_super_diag,
   input  logic signed [tts_pkg::DATA_W-1:0] req_rhs,
   input  logic                          req_last_row,
   output logic signed [tts_pkg::DATA_W-1:0] rsp_solution_value,
   output logic [tts_pkg::IDX_W-1:0]     rsp_row_index,
   output logic                          rsp_last_of_run,
   output logic                          rsp_singular,
   output logic                          rsp_saturated
);
   import tts_pkg::*;

   localparam int AW = $clog2(MAX_ROWS);
   localparam int NW = DATA_W + FRAC_BITS;
   localparam logic [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};

   // clip a wide difference to 32 bits, flag in the top bit
   function automatic logic [DATA_W:0] sat_wide(input logic signed [65:0] v);
      logic clip;
      clip = (v[65:DATA_W-1] != '0) && (v[65:DATA_W-1] != '1);
      if (clip) begin
         sat_wide = {1'b1, v[65] ? VMIN : VMAX};
      end else begin
         sat_wide = {1'b0, v[DATA_W-1:0]};
      end
   endfunction

   // apply the sign to a quotient magnitude and clip
   function automatic logic [DATA_W:0] sat_quo(input logic [NW-1:0] mag, input logic neg);
      logic [NW-1:0] lim;
      lim = NW'(VMAX);
      if (neg) begin
         if (mag > lim + 1'b1) begin
            sat_quo = {1'b1, VMIN};
         end else begin
            sat_quo = {1'b0, 32'(-mag)};
         end
      end else begin
         if (mag > lim) begin
            sat_quo = {1'b1, VMAX};
         end else begin
            sat_quo = {1'b0, mag[DATA_W-1:0]};
         end
      end
   endfunction

   function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
      mag32 = v[DATA_W-1] ? DATA_W'(-v) : v;
   endfunction

   logic signed [DATA_W-1:0] a_ff, b_ff, c_ff, d_ff;
   logic                     last_ff;
   logic [AW-1:0]            row_ff, idx_ff;
   logic signed [DATA_W-1:0] prev_sc_ff, prev_sr_ff;
   logic signed [63:0]       prod_c_ff, prod_d_ff, prod_b_ff;
   logic signed [DATA_W-1:0] piv_ff, numd_ff, next_ff;
   logic                     sing_ff, sat_ff, first_ff;
   logic signed [DATA_W-1:0] out_val_ff;
   logic [AW-1:0]            out_idx_ff;
   logic                     out_last_ff, out_sing_ff, out_sat_ff;

   logic                     final_row;
   logic [DATA_W:0]          piv_s, numd_s, sc_s, sr_s, x_s;
   logic signed [65:0]       piv_w, numd_w, x_w;
   logic [NW-1:0]            qc, qd;
   logic                     done_c, done_d;
   logic [2*DATA_W-1:0]      ram_rd;
   logic signed [DATA_W-1:0] rd_sc, rd_sr;
   logic signed [DATA_W-1:0] sc_wr, sr_wr;
   logic                     piv_zero;

   assign final_row = last_ff || (row_ff == AW'(MAX_ROWS - 1));
   assign piv_zero  = piv_ff == '0;

   assign piv_w  = 66'(b_ff) - 66'(prod_c_ff >>> FRAC_BITS);
   assign numd_w = 66'(d_ff) - 66'(prod_d_ff >>> FRAC_BITS);
   assign piv_s  = sat_wide(piv_w);
   assign numd_s = sat_wide(numd_w);

   tts_div #(.NW(NW)) u_div_c (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({mag32(c_ff), {FRAC_BITS{1'b0}}}),
      .divisor  (mag32(piv_ff)),
      .quotient (qc),
      .done     (done_c)
   );

   tts_div #(.NW(NW)) u_div_d (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({mag32(numd_ff), {FRAC_BITS{1'b0}}}),
      .divisor  (mag32(piv_ff)),
      .quotient (qd),
      .done     (done_d)
   );

   assign sc_s  = sat_quo(qc, c_ff[DATA_W-1] ^ piv_ff[DATA_W-1]);
   assign sr_s  = sat_quo(qd, numd_ff[DATA_W-1] ^ piv_ff[DATA_W-1]);
   assign sc_wr = (piv_zero || final_row) ? '0 : sc_s[DATA_W-1:0];
   assign sr_wr = piv_zero ? '0 : sr_s[DATA_W-1:0];

   tts_ram #(.WIDTH(2 * DATA_W), .DEPTH(MAX_ROWS)) u_store (
      .clock (clock),
      .we    (cmd.fwd_write),
      .waddr (row_ff),
      .wdata ({sc_wr, sr_wr}),
      .raddr (idx_ff),
      .rdata (ram_rd)
   );

   assign rd_sc = ram_rd[2*DATA_W-1:DATA_W];
   assign rd_sr = ram_rd[DATA_W-1:0];
   assign x_w   = 66'(rd_sr) - 66'(prod_b_ff >>> FRAC_BITS);
   assign x_s   = first_ff ? {1'b0, rd_sr} : sat_wide(x_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         sing_ff <= 1'b0;
         sat_ff  <= 1'b0;
      end else begin
         if (cmd.calc_piv && row_ff != '0) begin
            sat_ff <= sat_ff | piv_s[DATA_W] | numd_s[DATA_W];
         end
         if (cmd.fwd_write) begin
            if (piv_zero) begin
               sing_ff <= 1'b1;
            end else begin
               sat_ff <= sat_ff | sr_s[DATA_W] | (sc_s[DATA_W] & ~final_row);
            end
            if (!final_row) begin
               row_ff <= row_ff + 1'b1;
            end
         end
         if (cmd.back_sub) begin
            sat_ff <= sat_ff | x_s[DATA_W];
         end
         if (cmd.run_clear) begin
            row_ff  <= '0;
            sing_ff <= 1'b0;
            sat_ff  <= 1'b0;
         end
      end
      if (cmd.load_in) begin
         a_ff    <= req_sub_diag;
         b_ff    <= req_main_diag;
         c_ff    <= req_super_diag;
         d_ff    <= req_rhs;
         last_ff <= req_last_row;
      end
      if (cmd.calc_prod) begin
         prod_c_ff <= prev_sc_ff * a_ff;
         prod_d_ff <= prev_sr_ff * a_ff;
      end
      if (cmd.calc_piv) begin
         if (row_ff == '0) begin
            piv_ff  <= b_ff;
            numd_ff <= d_ff;
         end else begin
            piv_ff  <= piv_s[DATA_W-1:0];
            numd_ff <= numd_s[DATA_W-1:0];
         end
      end
      if (cmd.fwd_write) begin
         prev_sc_ff <= sc_wr;
         prev_sr_ff <= sr_wr;
         idx_ff     <= row_ff;
         first_ff   <= 1'b1;
      end
      if (cmd.back_mul) begin
         prod_b_ff <= rd_sc * next_ff;
      end
      if (cmd.back_sub) begin
         next_ff     <= x_s[DATA_W-1:0];
         first_ff    <= 1'b0;
         out_val_ff  <= sing_ff ? '0 : x_s[DATA_W-1:0];
         out_idx_ff  <= idx_ff;
         out_last_ff <= idx_ff == '0;
         out_sing_ff <= sing_ff;
         out_sat_ff  <= sat_ff | x_s[DATA_W];
      end
      if (cmd.idx_dec) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   assign stat.piv_zero  = piv_zero;
   assign stat.div_done  = done_c & done_d;
   assign stat.final_row = final_row;
   assign stat.idx_zero  = idx_ff == '0;

   assign rsp_solution_value = out_val_ff;
   assign rsp_row_index      = IDX_W'(out_idx_ff);
   assign rsp_last_of_run    = out_last_ff;
   assign rsp_singular       = out_sing_ff;
   assign rsp_saturated      = out_sat_ff;
endmodule

>>> hw/rtl/tridiagonal_thomas_solver.sv
// Thomas-algorithm tridiagonal solver, signed fixed point with FRAC_BITS fraction bits.
// Rows are sent in ascending order, one transfer each; a new row is taken only after the
// last one is written, which waits on the pair of bit-per-cycle dividers that scale the
// super-diagonal and right-hand side by the pivot. The row flagged last, or row
// MAX_ROWS-1, starts back substitution, which returns one result per unknown from the
// highest index down to 0, each held until the result side takes it.
// A zero pivot forces every value of the run to 0 and sets singular; any clip sets the
// sticky saturated flag. After the result for index 0 the block is ready for a new system.
module tridiagonal_thomas_solver #(
   parameter int MAX_ROWS  = tts_pkg::DEF_MAX_ROWS,
   parameter int FRAC_BITS = tts_pkg::DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [tts_pkg::DATA_W-1:0] req_sub_diag,
   input  logic signed [tts_pkg::DATA_W-1:0] req_main_diag,
   input  logic signed [tts_pkg::DATA_W-1:0] req_super_diag,
   input  logic signed [tts_pkg::DATA_W-1:0] req_rhs,
   input  logic                              req_last_row,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [tts_pkg::DATA_W-1:0] rsp_solution_value,
   output logic [tts_pkg::IDX_W-1:0]         rsp_row_index,
   output logic                              rsp_last_of_run,
   output logic                              rsp_singular,
   output logic                              rsp_saturated
);
   import tts_pkg::*;

   tts_cmd_type  cmd;
   tts_stat_type stat;

   tts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tts_dp #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_sub_diag       (req_sub_diag),
      .req_main_diag      (req_main_diag),
      .req_super_diag     (req_super_diag),
      .req_rhs            (req_rhs),
      .req_last_row       (req_last_row),
      .rsp_solution_value (rsp_solution_value),
      .rsp_row_index      (rsp_row_index),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_singular       (rsp_singular),
      .rsp_saturated      (rsp_saturated)
   );
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

class thomas_scoreboard;
   logic signed [31:0] sc_mem [64];
   logic signed [31:0] sr_mem [64];
   int unsigned        rows;
   bit                 sing;
   bit                 satf;
   logic [40:0]        solutions [$];
   int                 errors;

   function new();
      rows = 0; sing = 0; satf = 0; errors = 0;
   endfunction

   function logic signed [31:0] clip(logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         satf = 1;
         return 32'sh7fffffff;
      end
      if (v < -66'sd2147483648) begin
         satf = 1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function logic signed [65:0] mul_q(logic signed [31:0] x, logic signed [31:0] y);
      logic signed [65:0] p;
      p = 66'(x) * 66'(y);
      return p >>> 24;
   endfunction

   function logic signed [31:0] div_q(logic signed [31:0] n, logic signed [31:0] p);
      logic signed [65:0] num;
      num = 66'(n) <<< 24;
      return clip(num / 66'(p));
   endfunction

   // forward sweep row, back substitution on the final row
   function void note_row(logic signed [31:0] a, b, c, d, bit last);
      logic signed [31:0] piv, nd, x;
      int unsigned        i;
      bit                 fin;
      i = rows % 64;
      fin = last || (i >= 63);
      if (i == 0) begin
         piv = b; nd = d;
      end else begin
         piv = clip(66'(b) - mul_q(sc_mem[i-1], a));
         nd = clip(66'(d) - mul_q(sr_mem[i-1], a));
      end
      if (piv == 0) begin
         sing = 1; sc_mem[i] = 0; sr_mem[i] = 0;
      end else begin
         sc_mem[i] = fin ? 32'sd0 : div_q(c, piv);
         sr_mem[i] = div_q(nd, piv);
      end
      if (!fin) begin
         rows = i + 1;
         return;
      end
      x = 0;
      for (int k = 0; k <= int'(i); k++) begin
         int unsigned idx;
         idx = i - k;
         if (k == 0) x = sr_mem[idx];
         else x = clip(66'(sr_mem[idx]) - mul_q(sc_mem[idx], x));
         solutions.insert(solutions.size(),
                          {sing ? 32'd0 : x, idx[5:0], idx == 0, sing, satf});
      end
      rows = 0; sing = 0; satf = 0;
   endfunction

   task check_solution(logic [31:0] v, logic [5:0] idx, bit lr, sg, st);
      logic [40:0] e;
      if (solutions.size() == 0) begin
         report("result with nothing expected");
         return;
      end
      e = solutions.pop_front();
      if (v !== e[40:9]) report($sformatf("idx %0d value %h exp %h", e[8:3], v, e[40:9]));
      if (idx !== e[8:3]) report($sformatf("row_index %0d exp %0d", idx, e[8:3]));
      if (lr !== e[2]) report($sformatf("idx %0d last_of_run %b", e[8:3], lr));
      if (sg !== e[1]) report($sformatf("idx %0d singular %b", e[8:3], sg));
      if (st !== e[0]) report($sformatf("idx %0d saturated %b", e[8:3], st));
   endtask

   task report(string s);
      $display("mismatch: %s", s);
      errors++;
   endtask
endclass

module tb_top;
   import tts_pkg::*;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_sub_diag = 0, req_main_diag = 0;
   logic signed [DATA_W-1:0] req_super_diag = 0, req_rhs = 0;
   logic                     req_last_row = 0;
   logic                     rsp_valid;
   logic                     rsp_ready = 0;
   logic signed [DATA_W-1:0] rsp_solution_value;
   logic [IDX_W-1:0]         rsp_row_index;
   logic                     rsp_last_of_run, rsp_singular, rsp_saturated;

   thomas_scoreboard sb = new();
   int               idle_cycles = 0;
   int               rsp_hold = 0;
   bit               draining = 0;

   always #4 clock = ~clock;

   tridiagonal_thomas_solver u_top (.*);

   function int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 120);
      return $urandom_range(0, 3);
   endfunction

   function logic [31:0] rand_coef(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
         default: return $signed($urandom_range(32'h800000, 32'h4000000));
      endcase
   endfunction

   task automatic send_row(logic [31:0] a, b, c, d, bit last);
      int g;
      g = gap_len();
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_sub_diag <= a; req_main_diag <= b; req_super_diag <= c; req_rhs <= d;
      req_last_row <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_row(a, b, c, d, last);
   endtask

   // random system; mode 2 gives a well-conditioned one with a dominant diagonal
   task automatic send_system(int n, int mode);
      for (int r = 0; r < n; r++) begin
         logic [31:0] b;
         b = (mode == 2) ? rand_coef(2) + 32'h2000000 : rand_coef(mode);
         send_row(rand_coef(mode == 2 ? 1 : mode), b, rand_coef(mode == 2 ? 1 : mode),
                  rand_coef(mode == 2 ? 1 : mode), r == n - 1);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_solution(rsp_solution_value, rsp_row_index, rsp_last_of_run,
                              rsp_singular, rsp_saturated);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("Verification failed");
            $finish;
         end
         if (draining) begin
            rsp_ready <= 1;
         end else if (rsp_hold > 0) begin
            rsp_hold  <= rsp_hold - 1;
            rsp_ready <= 0;
         end else if ($urandom_range(0, 9) < 7) begin
            rsp_ready <= 1;
         end else begin
            rsp_ready <= 0;
            rsp_hold  <= gap_len();
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, singular, saturation, single row
      send_row(32'h7fffffff, 32'h01000000, 32'h80000000, 32'h7fffffff, 1);
      send_row(32'h80000000, 32'h00000000, 32'h7fffffff, 32'h80000000, 1);
      send_row(0, 32'h00000001, 32'h7fffffff, 32'h7fffffff, 0);
      send_row(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h80000000, 0);
      send_row(32'hffffffff, 32'h7fffffff, 32'h0, 32'h1, 1);
      send_row(32'h5, 32'h01000000, 32'h00800000, 32'h02000000, 0);
      send_row(32'h00800000, 32'h00400000, 32'h7fffffff, 32'h01000000, 1);
      send_row(0, 32'h01000000, 32'h01000000, 32'h01000000, 0);
      send_row(32'h01000000, 32'h01000000, 0, 32'h01000000, 1);
      req_valid <= 0;
      while (sb.solutions.size() != 0) @(posedge clock);
      send_system(64, 2);
      // row limit without the last flag
      for (int r = 0; r < 64; r++)
         send_row(rand_coef(1), rand_coef(2) + 32'h2000000, rand_coef(1), rand_coef(1), 0);
      for (int s = 0; s < 47; s++) begin
         int m;
         m = $urandom_range(0, 9);
         send_system($urandom_range(1, 6), m < 6 ? 2 : (m < 8 ? 1 : 0));
      end
      req_valid <= 0;
      while (sb.solutions.size() != 0) @(posedge clock);
      draining = 1;
      repeat (400) @(posedge clock);
      if (sb.errors == 0 && sb.solutions.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
